/* rtl/assert_macros.svh */
// Assertion macros shared by the checker files.
// No dependencies; include once per compilation unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MVN_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mesh normals assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MVN_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mesh normals assertion failed");

`endif

/* rtl/mvn_pkg.sv */
// Shared constants, types and helper functions for the mesh normals block.
// No dependencies.
package mvn_pkg;

  localparam int MAX_VERTICES  = 1024;
  localparam int MAX_TRIANGLES = 1024;
  localparam int COORD_BITS    = 16;

  localparam int VA_W  = $clog2(MAX_VERTICES);
  localparam int TA_W  = $clog2(MAX_TRIANGLES);
  localparam int VC_W  = $clog2(MAX_VERTICES + 1);
  localparam int TC_W  = $clog2(MAX_TRIANGLES + 1);

  localparam int IDX_W = 10;
  localparam int CNT_W = 11;
  localparam int IN_CW = 16;
  localparam int NRM_W = 16;
  localparam int SUM_W = 26;

  localparam int DW = COORD_BITS + 1;
  localparam int EW = (DW > 31) ? 31 : DW;
  localparam int PW = 2 * EW;
  localparam int CW = (PW + 1 > SUM_W) ? PW + 1 : SUM_W;
  localparam int MW = (CW > 21) ? CW : 21;

  localparam int SCL_BITS = 20;
  localparam int FS_FACE  = 13;
  localparam int FS_READ  = 14;
  localparam int NUM_W    = SCL_BITS + FS_READ + 10 + 1;
  localparam int SQ_W     = 2 * SCL_BITS + 2;
  localparam int RAD_W    = SQ_W + SCL_BITS;
  localparam int LEN_W    = 32;
  localparam int DCNT_W   = $clog2(NUM_W);
  localparam int NRM_ONE  = 1 << FS_READ;

  localparam int VTX_W  = 3 * COORD_BITS;
  localparam int TRI_W  = 3 * IDX_W;
  localparam int SUMS_W = 3 * SUM_W;

  localparam int CFG_IW = 1;
  localparam logic [CFG_IW-1:0] REG_VCOUNT = 1'b0;
  localparam logic [CFG_IW-1:0] REG_TCOUNT = 1'b1;

  typedef enum logic [1:0] {
    MODE_LOAD_V, MODE_LOAD_T, MODE_COMPUTE, MODE_READ
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK, ST_RANGE, ST_MISSING
  } status_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_ACCEPT, OP_CLR, OP_TRI_RD, OP_TRI_CHK, OP_VB, OP_VC, OP_VE,
    OP_SHRINK, OP_MUL, OP_MAG, OP_SCALE, OP_SQ, OP_SQRT_INIT, OP_SQRT,
    OP_DIV_INIT, OP_DIV, OP_DIV_DONE, OP_ACC_RD, OP_ACC_WR, OP_TRI_NEXT,
    OP_SUM_RD, OP_SUM_LD, OP_FIN
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_CLEAR, S_TRI_RD, S_TRI_CHK, S_VB, S_VC, S_VE,
    S_SHRINK, S_MUL, S_MAG, S_SCALE, S_SQ, S_SQRT_INIT, S_SQRT, S_DIV_INIT,
    S_DIV, S_DIV_DONE, S_ACC_RD, S_ACC_WR, S_TRI_NEXT, S_SUM_LD, S_FIN
  } state_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  in_rng;
    logic  computed;
    logic  clr_last;
    logic  tri_end;
    logic  corner_bad;
    logic  shrink_more;
    logic  mul_last;
    logic  mag_zero;
    logic  scale_done;
    logic  sq_last;
    logic  sqrt_last;
    logic  div_last;
    logic  comp_last;
    logic  corner_last;
    logic  out_free;
  } sts_t;

  function automatic logic signed [COORD_BITS-1:0] coord_of(input logic [IN_CW-1:0] raw);
    logic [47:0] w;
    w = 48'(raw);
    return w[COORD_BITS-1:0];
  endfunction

  function automatic logic [VA_W-1:0] vaddr(input logic [IDX_W-1:0] i);
    logic [31:0] w;
    w = 32'(i);
    return w[VA_W-1:0];
  endfunction

  function automatic logic [TA_W-1:0] taddr(input logic [IDX_W-1:0] i);
    logic [31:0] w;
    w = 32'(i);
    return w[TA_W-1:0];
  endfunction

  function automatic logic too_wide(input logic signed [DW-1:0] d);
    logic signed [63:0] w;
    w = 64'(d);
    return (w >= 64'sd1073741824) || (w <= -64'sd1073741824);
  endfunction

  // halve toward zero
  function automatic logic signed [DW-1:0] half_tz(input logic signed [DW-1:0] d);
    logic signed [DW-1:0] t;
    t = d + $signed({{(DW-1){1'b0}}, d[DW-1]});
    return t >>> 1;
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W-1:0] s,
                                                      input logic signed [NRM_W-1:0] n);
    logic signed [SUM_W:0] t;
    t = (SUM_W+1)'(s) + (SUM_W+1)'(n);
    if (t[SUM_W] != t[SUM_W-1]) begin
      return t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end
    return t[SUM_W-1:0];
  endfunction

endpackage

/* rtl/mvn_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module mvn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

/* rtl/mvn_ctrl.sv */
// Sequencer for the mesh normals block: picks one datapath op per cycle.
// Depends on mvn_pkg.
module mvn_ctrl import mvn_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  output logic   in_ready,
  input  sts_t   sts,
  output cmd_t   cmd
);
  state_t state_r, state_nxt;
  logic   is_read;

  assign is_read = (sts.mode == MODE_READ);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:      if (in_valid) state_nxt = S_DISPATCH;
      S_DISPATCH: begin
        priority if (sts.mode == MODE_COMPUTE) begin
          state_nxt = S_CLEAR;
        end else if (is_read && sts.in_rng && sts.computed) begin
          state_nxt = S_SUM_LD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_CLEAR:     if (sts.clr_last) state_nxt = S_TRI_RD;
      S_TRI_RD:    state_nxt = sts.tri_end ? S_FIN : S_TRI_CHK;
      S_TRI_CHK:   state_nxt = sts.corner_bad ? S_TRI_NEXT : S_VB;
      S_VB:        state_nxt = S_VC;
      S_VC:        state_nxt = S_VE;
      S_VE:        state_nxt = S_SHRINK;
      S_SHRINK:    if (!sts.shrink_more) state_nxt = S_MUL;
      S_MUL:       if (sts.mul_last) state_nxt = S_MAG;
      S_SUM_LD:    state_nxt = S_MAG;
      S_MAG: begin
        if (sts.mag_zero) begin
          state_nxt = is_read ? S_FIN : S_TRI_NEXT;
        end else begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE:     if (sts.scale_done) state_nxt = S_SQ;
      S_SQ:        if (sts.sq_last) state_nxt = S_SQRT_INIT;
      S_SQRT_INIT: state_nxt = S_SQRT;
      S_SQRT:      if (sts.sqrt_last) state_nxt = S_DIV_INIT;
      S_DIV_INIT:  state_nxt = S_DIV;
      S_DIV:       if (sts.div_last) state_nxt = S_DIV_DONE;
      S_DIV_DONE: begin
        if (sts.comp_last) begin
          state_nxt = is_read ? S_FIN : S_ACC_RD;
        end else begin
          state_nxt = S_DIV_INIT;
        end
      end
      S_ACC_RD:    state_nxt = S_ACC_WR;
      S_ACC_WR:    state_nxt = sts.corner_last ? S_TRI_NEXT : S_ACC_RD;
      S_TRI_NEXT:  state_nxt = S_TRI_RD;
      S_FIN:       if (sts.out_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.op   = OP_NONE;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_ACCEPT;
      end
      S_DISPATCH:  if (is_read && sts.in_rng && sts.computed) cmd.op = OP_SUM_RD;
      S_CLEAR:     cmd.op = OP_CLR;
      S_TRI_RD:    if (!sts.tri_end) cmd.op = OP_TRI_RD;
      S_TRI_CHK:   cmd.op = OP_TRI_CHK;
      S_VB:        cmd.op = OP_VB;
      S_VC:        cmd.op = OP_VC;
      S_VE:        cmd.op = OP_VE;
      S_SHRINK:    cmd.op = OP_SHRINK;
      S_MUL:       cmd.op = OP_MUL;
      S_SUM_LD:    cmd.op = OP_SUM_LD;
      S_MAG:       cmd.op = OP_MAG;
      S_SCALE:     cmd.op = OP_SCALE;
      S_SQ:        cmd.op = OP_SQ;
      S_SQRT_INIT: cmd.op = OP_SQRT_INIT;
      S_SQRT:      cmd.op = OP_SQRT;
      S_DIV_INIT:  cmd.op = OP_DIV_INIT;
      S_DIV:       cmd.op = OP_DIV;
      S_DIV_DONE:  cmd.op = OP_DIV_DONE;
      S_ACC_RD:    cmd.op = OP_ACC_RD;
      S_ACC_WR:    cmd.op = OP_ACC_WR;
      S_TRI_NEXT:  cmd.op = OP_TRI_NEXT;
      S_FIN:       if (sts.out_free) cmd.op = OP_FIN;
      default:     cmd.op = OP_NONE;
    endcase
  end
endmodule

/* rtl/mvn_dp.sv */
// Datapath of the mesh normals block: stores, cross product, normalizer.
// Depends on mvn_pkg and mvn_ram.
module mvn_dp import mvn_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  logic [1:0]              in_mode,
  input  logic [IDX_W-1:0]        in_item_index,
  input  logic signed [IN_CW-1:0] in_coord_x,
  input  logic signed [IN_CW-1:0] in_coord_y,
  input  logic signed [IN_CW-1:0] in_coord_z,
  input  logic [IDX_W-1:0]        in_corner_a,
  input  logic [IDX_W-1:0]        in_corner_b,
  input  logic [IDX_W-1:0]        in_corner_c,
  input  logic                    cfg_valid,
  input  logic [CFG_IW-1:0]       cfg_index,
  input  logic [CNT_W-1:0]        cfg_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_status,
  output logic [IDX_W-1:0]        out_vertex_number,
  output logic signed [NRM_W-1:0] out_normal_x,
  output logic signed [NRM_W-1:0] out_normal_y,
  output logic signed [NRM_W-1:0] out_normal_z
);
  // configuration
  logic [CNT_W-1:0] vcount_r, tcount_r;
  logic [VC_W-1:0]  veff;
  logic [TC_W-1:0]  teff;

  assign veff = (32'(vcount_r) > MAX_VERTICES) ? VC_W'(MAX_VERTICES) : VC_W'(vcount_r);
  assign teff = (32'(tcount_r) > MAX_TRIANGLES) ? TC_W'(MAX_TRIANGLES) : TC_W'(tcount_r);

  // item registers
  mode_t            mode_r;
  logic [IDX_W-1:0] item_r;
  logic             rng_r, computed_r, err_r;
  logic [VA_W-1:0]  clr_addr_r;
  logic [TC_W-1:0]  tri_r;
  logic [IDX_W-1:0] k_r [3];

  logic signed [COORD_BITS-1:0] p_r [3], q_r [3];
  logic signed [DW-1:0]         s_r [3], e_r [3];
  logic signed [CW-1:0]         c_r [3];
  logic [MW-1:0]                m_r [3];
  logic                         neg_r [3];
  logic signed [NRM_W-1:0]      n_r [3];

  logic [2:0]        mstep_r;
  logic [1:0]        sqj_r, dj_r, aj_r;
  logic [SQ_W-1:0]   l2_r;
  logic [RAD_W-1:0]  v_r;
  logic [RAD_W:0]    r_r, bit_r;
  logic [NUM_W-1:0]  num_r;
  logic [LEN_W:0]    rem_r;
  logic [DCNT_W-1:0] dcnt_r;

  logic                    out_valid_r;
  status_t                 out_status_r;
  logic [IDX_W-1:0]        out_vnum_r;
  logic signed [NRM_W-1:0] out_n_r [3];

  // memories
  logic              v_we, t_we, s_we, v_re, t_re, s_re;
  logic [VA_W-1:0]   v_raddr, s_waddr, s_raddr;
  logic [VTX_W-1:0]  v_rdata;
  logic [TRI_W-1:0]  t_rdata;
  logic [SUMS_W-1:0] s_wdata, s_rdata;

  mode_t in_mode_e;
  logic  in_rng;
  logic  is_read;

  assign in_mode_e = mode_t'(in_mode);
  assign is_read   = (mode_r == MODE_READ);

  always_comb begin
    unique case (in_mode_e)
      MODE_LOAD_T:  in_rng = 32'(in_item_index) < 32'(teff);
      MODE_COMPUTE: in_rng = 1'b1;
      default:      in_rng = 32'(in_item_index) < 32'(veff);
    endcase
  end

  assign v_we = (cmd.op == OP_ACCEPT) && (in_mode_e == MODE_LOAD_V) && in_rng;
  assign t_we = (cmd.op == OP_ACCEPT) && (in_mode_e == MODE_LOAD_T) && in_rng;

  mvn_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_vtx (
    .clk(clk), .we(v_we), .waddr(vaddr(in_item_index)),
    .wdata({coord_of(in_coord_z), coord_of(in_coord_y), coord_of(in_coord_x)}),
    .re(v_re), .raddr(v_raddr), .rdata(v_rdata)
  );

  mvn_ram #(.WIDTH(TRI_W), .DEPTH(MAX_TRIANGLES)) u_tri (
    .clk(clk), .we(t_we), .waddr(taddr(in_item_index)),
    .wdata({in_corner_c, in_corner_b, in_corner_a}),
    .re(t_re), .raddr(tri_r[TA_W-1:0]), .rdata(t_rdata)
  );

  mvn_ram #(.WIDTH(SUMS_W), .DEPTH(MAX_VERTICES)) u_sum (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .re(s_re), .raddr(s_raddr), .rdata(s_rdata)
  );

  // read data views
  logic [IDX_W-1:0]        t_corner [3];
  logic signed [COORD_BITS-1:0] v_co [3];
  logic signed [SUM_W-1:0] s_co [3];
  logic [IDX_W-1:0]        acc_k;
  logic                    corner_bad;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t_corner[k] = t_rdata[k*IDX_W +: IDX_W];
      v_co[k]     = $signed(v_rdata[k*COORD_BITS +: COORD_BITS]);
      s_co[k]     = $signed(s_rdata[k*SUM_W +: SUM_W]);
    end
  end

  assign corner_bad = (32'(t_corner[0]) >= 32'(veff)) || (32'(t_corner[1]) >= 32'(veff)) ||
                      (32'(t_corner[2]) >= 32'(veff));
  assign acc_k = k_r[aj_r];

  assign t_re = (cmd.op == OP_TRI_RD);
  assign v_re = (cmd.op == OP_TRI_CHK) || (cmd.op == OP_VB) || (cmd.op == OP_VC);
  always_comb begin
    unique case (cmd.op)
      OP_VB:   v_raddr = vaddr(k_r[1]);
      OP_VC:   v_raddr = vaddr(k_r[2]);
      default: v_raddr = vaddr(t_corner[0]);
    endcase
  end

  assign s_re    = (cmd.op == OP_SUM_RD) || (cmd.op == OP_ACC_RD);
  assign s_raddr = (cmd.op == OP_SUM_RD) ? vaddr(item_r) : vaddr(acc_k);
  assign s_we    = (cmd.op == OP_CLR) || (cmd.op == OP_ACC_WR);
  assign s_waddr = (cmd.op == OP_CLR) ? clr_addr_r : vaddr(acc_k);
  assign s_wdata = (cmd.op == OP_CLR) ? '0 :
                   {sat_sum(s_co[2], n_r[2]), sat_sum(s_co[1], n_r[1]), sat_sum(s_co[0], n_r[0])};

  // shared arithmetic
  logic signed [EW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic [1:0]           mj;

  always_comb begin
    unique case (mstep_r)
      3'd0:    begin mul_a = $signed(s_r[1][EW-1:0]); mul_b = $signed(e_r[2][EW-1:0]); end
      3'd1:    begin mul_a = $signed(s_r[2][EW-1:0]); mul_b = $signed(e_r[1][EW-1:0]); end
      3'd2:    begin mul_a = $signed(s_r[2][EW-1:0]); mul_b = $signed(e_r[0][EW-1:0]); end
      3'd3:    begin mul_a = $signed(s_r[0][EW-1:0]); mul_b = $signed(e_r[2][EW-1:0]); end
      3'd4:    begin mul_a = $signed(s_r[0][EW-1:0]); mul_b = $signed(e_r[1][EW-1:0]); end
      default: begin mul_a = $signed(s_r[1][EW-1:0]); mul_b = $signed(e_r[0][EW-1:0]); end
    endcase
  end
  assign prod = mul_a * mul_b;
  assign mj   = mstep_r[2:1];

  logic [MW-1:0] mx;
  logic          mx_hi, mx_lo, shr_s, shr_e;
  assign mx = (m_r[0] > m_r[1]) ? ((m_r[0] > m_r[2]) ? m_r[0] : m_r[2]) :
                                  ((m_r[1] > m_r[2]) ? m_r[1] : m_r[2]);
  assign mx_hi = mx >= (MW'(1) << SCL_BITS);
  assign mx_lo = mx <  (MW'(1) << (SCL_BITS - 1));
  assign shr_s = too_wide(s_r[0]) || too_wide(s_r[1]) || too_wide(s_r[2]);
  assign shr_e = too_wide(e_r[0]) || too_wide(e_r[1]) || too_wide(e_r[2]);

  logic [SCL_BITS-1:0]   sq_in;
  logic [2*SCL_BITS-1:0] sq;
  assign sq_in = m_r[sqj_r][SCL_BITS-1:0];
  assign sq    = sq_in * sq_in;

  logic [RAD_W:0] rb;
  assign rb = r_r + bit_r;

  logic [LEN_W-1:0] len;
  logic [LEN_W:0]   rem_sh;
  logic             qbit;
  assign len    = r_r[LEN_W-1:0];
  assign rem_sh = {rem_r[LEN_W-1:0], num_r[NUM_W-1]};
  assign qbit   = rem_sh >= {1'b0, len};

  logic [NUM_W-1:0] mnum, num_init, one, qc;
  logic [NRM_W-1:0] qv;
  assign mnum     = NUM_W'(m_r[dj_r][SCL_BITS-1:0]);
  assign num_init = (is_read ? (mnum << (FS_READ + 10)) : (mnum << (FS_FACE + 10))) +
                    NUM_W'(len >> 1);
  assign one      = is_read ? (NUM_W'(1) << FS_READ) : (NUM_W'(1) << FS_FACE);
  assign qc       = (num_r > one) ? one : num_r;
  assign qv       = qc[NRM_W-1:0];

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r    <= '0;
      tcount_r    <= '0;
      computed_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_VCOUNT: vcount_r <= cfg_data;
          REG_TCOUNT: tcount_r <= cfg_data;
          default:    vcount_r <= vcount_r;
        endcase
      end
      if (cmd.op == OP_CLR) computed_r <= 1'b1;
      if (cmd.op == OP_FIN) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and work registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_ACCEPT: begin
        mode_r     <= in_mode_e;
        item_r     <= in_item_index;
        rng_r      <= in_rng;
        clr_addr_r <= '0;
        tri_r      <= '0;
        err_r      <= 1'b0;
        for (int k = 0; k < 3; k++) n_r[k] <= '0;
      end
      OP_CLR:     clr_addr_r <= clr_addr_r + 1'b1;
      OP_TRI_CHK: begin
        for (int k = 0; k < 3; k++) k_r[k] <= t_corner[k];
        if (corner_bad) err_r <= 1'b1;
      end
      OP_VB:      for (int k = 0; k < 3; k++) p_r[k] <= v_co[k];
      OP_VC:      for (int k = 0; k < 3; k++) q_r[k] <= v_co[k];
      OP_VE: begin
        for (int k = 0; k < 3; k++) begin
          s_r[k] <= DW'(q_r[k]) - DW'(p_r[k]);
          e_r[k] <= DW'(v_co[k]) - DW'(q_r[k]);
        end
        mstep_r <= '0;
      end
      OP_SHRINK: begin
        for (int k = 0; k < 3; k++) begin
          if (shr_s) s_r[k] <= half_tz(s_r[k]);
          if (shr_e) e_r[k] <= half_tz(e_r[k]);
        end
      end
      OP_MUL: begin
        if (!mstep_r[0]) begin
          c_r[mj] <= CW'(prod);
        end else begin
          c_r[mj] <= c_r[mj] - CW'(prod);
        end
        mstep_r <= mstep_r + 1'b1;
      end
      OP_SUM_LD:  for (int k = 0; k < 3; k++) c_r[k] <= CW'(s_co[k]);
      OP_MAG: begin
        for (int k = 0; k < 3; k++) begin
          neg_r[k] <= c_r[k][CW-1];
          m_r[k]   <= MW'(c_r[k][CW-1] ? (~c_r[k] + 1'b1) : c_r[k]);
          n_r[k]   <= '0;
        end
        l2_r  <= '0;
        sqj_r <= '0;
        dj_r  <= '0;
        aj_r  <= '0;
      end
      OP_SCALE: begin
        for (int k = 0; k < 3; k++) begin
          if (mx_hi) begin
            m_r[k] <= m_r[k] >> 1;
          end else if (mx_lo) begin
            m_r[k] <= m_r[k] << 1;
          end
        end
      end
      OP_SQ: begin
        l2_r  <= l2_r + SQ_W'(sq);
        sqj_r <= sqj_r + 1'b1;
      end
      OP_SQRT_INIT: begin
        v_r   <= {l2_r, {SCL_BITS{1'b0}}};
        r_r   <= '0;
        bit_r <= (RAD_W+1)'(1) << (RAD_W - 1'b1 - ((RAD_W - 1) % 2));
      end
      OP_SQRT: begin
        if ({1'b0, v_r} >= rb) begin
          v_r <= v_r - rb[RAD_W-1:0];
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      OP_DIV_INIT: begin
        num_r  <= num_init;
        rem_r  <= '0;
        dcnt_r <= '0;
      end
      OP_DIV: begin
        rem_r  <= qbit ? (rem_sh - {1'b0, len}) : rem_sh;
        num_r  <= {num_r[NUM_W-2:0], qbit};
        dcnt_r <= dcnt_r + 1'b1;
      end
      OP_DIV_DONE: begin
        n_r[dj_r] <= neg_r[dj_r] ? -$signed(qv) : $signed(qv);
        dj_r      <= dj_r + 1'b1;
      end
      OP_ACC_WR:   aj_r  <= aj_r + 1'b1;
      OP_TRI_NEXT: tri_r <= tri_r + 1'b1;
      OP_FIN: begin
        unique case (mode_r)
          MODE_COMPUTE: out_status_r <= err_r ? ST_MISSING : ST_OK;
          default:      out_status_r <= rng_r ? ST_OK : ST_RANGE;
        endcase
        out_vnum_r <= is_read ? item_r : '0;
        // only a read returns a normal; compute leaves the last face in n_r
        for (int k = 0; k < 3; k++) out_n_r[k] <= is_read ? n_r[k] : '0;
      end
      default: mode_r <= mode_r;
    endcase
  end

  always_comb begin
    sts.mode        = mode_r;
    sts.in_rng      = rng_r;
    sts.computed    = computed_r;
    sts.clr_last    = (clr_addr_r == VA_W'(MAX_VERTICES - 1));
    sts.tri_end     = (tri_r >= teff);
    sts.corner_bad  = corner_bad;
    sts.shrink_more = shr_s || shr_e;
    sts.mul_last    = (mstep_r == 3'd5);
    sts.mag_zero    = (c_r[0] == '0) && (c_r[1] == '0) && (c_r[2] == '0);
    sts.scale_done  = !mx_hi && !mx_lo;
    sts.sq_last     = (sqj_r == 2'd2);
    sts.sqrt_last   = bit_r[0];
    sts.div_last    = (dcnt_r == DCNT_W'(NUM_W - 1));
    sts.comp_last   = (dj_r == 2'd2);
    sts.corner_last = (aj_r == 2'd2);
    sts.out_free    = !out_valid_r || out_ready;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_vertex_number = out_vnum_r;
  assign out_normal_x      = out_n_r[0];
  assign out_normal_y      = out_n_r[1];
  assign out_normal_z      = out_n_r[2];
endmodule

/* rtl/mesh_vertex_normals.sv */
// Top level of the mesh vertex normals block: sequencer plus datapath.
// Depends on mvn_pkg, mvn_ctrl, mvn_dp (and mvn_ram through the datapath).
//
// Usage:
//   in_* channel (valid/ready) carries one command beat: load vertex, load
//   triangle, compute normals, or read a vertex normal (in_mode).
//   out_* channel returns exactly one result beat per command, in order.
//   cfg_* channel writes vertex_count (index 0) or triangle_count (index 1);
//   cfg_ready is always high, writes belong between commands.
// Sequence (one command in flight at a time):
//   loads, reads before the first compute and out-of-range reads: the result
//   is registered straight after dispatch, with no normalizer pass.
//   in-range read: one pass of the shared normalizer
//   (1 to 20 magnitude scaling steps, 31 square-root steps, three
//   restoring divisions).
//   compute: a sweep that clears all 1024 accumulator RAM entries, then per
//   triangle the normalizer plus three read-modify-write beats
//   on the accumulator RAM; a zero-area face skips both, and a triangle with
//   a missing corner is skipped.
// Reset clears the counts, the output valid and the computed flag; reads
//   before the first compute return zero normals. The stores hold garbage
//   until loaded.
// Output stall: the result sits in an output register; the next command
//   is still accepted and its result waits until the register frees up.
module mesh_vertex_normals import mvn_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [1:0]              in_mode,
  input  logic [IDX_W-1:0]        in_item_index,
  input  logic signed [IN_CW-1:0] in_coord_x,
  input  logic signed [IN_CW-1:0] in_coord_y,
  input  logic signed [IN_CW-1:0] in_coord_z,
  input  logic [IDX_W-1:0]        in_corner_a,
  input  logic [IDX_W-1:0]        in_corner_b,
  input  logic [IDX_W-1:0]        in_corner_c,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_status,
  output logic [IDX_W-1:0]        out_vertex_number,
  output logic signed [NRM_W-1:0] out_normal_x,
  output logic signed [NRM_W-1:0] out_normal_y,
  output logic signed [NRM_W-1:0] out_normal_z,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IW-1:0]       cfg_index,
  input  logic [CNT_W-1:0]        cfg_data
);
  cmd_t cmd;
  sts_t sts;

  // config registers are plain flops, a write beat is always taken
  assign cfg_ready = 1'b1;

  mvn_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  mvn_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_mode(in_mode), .in_item_index(in_item_index),
    .in_coord_x(in_coord_x), .in_coord_y(in_coord_y), .in_coord_z(in_coord_z),
    .in_corner_a(in_corner_a), .in_corner_b(in_corner_b), .in_corner_c(in_corner_c),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
    .out_vertex_number(out_vertex_number),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y), .out_normal_z(out_normal_z)
  );
endmodule

/* rtl/mvn_checker.sv */
// Port-level checks for the mesh normals block, bound to the top level.
// Depends on mvn_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mvn_checker import mvn_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [1:0]              out_status,
  input logic signed [NRM_W-1:0] out_normal_x,
  input logic signed [NRM_W-1:0] out_normal_y,
  input logic signed [NRM_W-1:0] out_normal_z
);
  localparam logic signed [NRM_W-1:0] ONE_P = NRM_W'(NRM_ONE);
  localparam logic signed [NRM_W-1:0] ONE_N = -NRM_W'(NRM_ONE);

  // stalled result beat holds
  `MVN_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_normal_x) && $stable(out_normal_y) && $stable(out_normal_z))

  // one command in flight: busy right after an accepted beat
  `MVN_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

  // error results carry zero normals
  `MVN_ASSERT_IMPL(a_err_zero, clk, rst_n, out_valid && (out_status != ST_OK), (out_normal_x == 0) && (out_normal_y == 0) && (out_normal_z == 0))

  // unit normals stay within one
  `MVN_ASSERT_IMPL(a_unit_range, clk, rst_n, out_valid, (out_normal_x <= ONE_P) && (out_normal_x >= ONE_N) && (out_normal_y <= ONE_P) && (out_normal_y >= ONE_N) && (out_normal_z <= ONE_P) && (out_normal_z >= ONE_N))
endmodule

bind mesh_vertex_normals mvn_checker u_mvn_checker (.*);
